[rtl/bta_pkg.sv]
// Shared types and constants for the button turbo auto-repeat block.
// Used by every module under rtl; depends on nothing else.
package bta_pkg;

  localparam int KEY_BITS       = 32;
  localparam int BUTTON_BITS    = 24;
  localparam int AXIS_BITS      = 8;
  localparam int TIME_BITS      = 48;
  localparam int CFG_DATA_BITS  = 32;
  localparam int CFG_INDEX_BITS = 2;
  localparam int NUM_KEYS_DEF   = 32;

  localparam logic [AXIS_BITS-1:0] AXIS_LOW  = AXIS_BITS'(64);
  localparam logic [AXIS_BITS-1:0] AXIS_HIGH = AXIS_BITS'(192);

  localparam logic [TIME_BITS-1:0] TIME_MAX = {TIME_BITS{1'b1}};

  // Configuration register indexes.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_TURBO_MASK      = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_START_DELAY     = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_REPEAT_INTERVAL = 2'd2;

  localparam logic [CFG_DATA_BITS-1:0] START_DELAY_RST     = 32'd500000;
  localparam logic [CFG_DATA_BITS-1:0] REPEAT_INTERVAL_RST = 32'd100000;

  typedef struct packed {
    logic [BUTTON_BITS-1:0] buttons;
    logic [AXIS_BITS-1:0]   left_x;
    logic [AXIS_BITS-1:0]   left_y;
    logic [AXIS_BITS-1:0]   right_x;
    logic [AXIS_BITS-1:0]   right_y;
    logic [TIME_BITS-1:0]   now;
  } in_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0] keys;
    logic [KEY_BITS-1:0] pressed;
    logic [KEY_BITS-1:0] released;
    logic                changed;
  } out_item_t;

  typedef struct packed {
    logic [KEY_BITS-1:0]      turbo_mask;
    logic [CFG_DATA_BITS-1:0] start_delay;
    logic [CFG_DATA_BITS-1:0] repeat_interval;
  } cfg_t;

endpackage

[rtl/bta_key_map.sv]
// Builds the 32-bit key word from one poll: button bits plus stick directions.
// Depends on bta_pkg.
module bta_key_map
  import bta_pkg::*;
(
  input  in_item_t            item,
  output logic [KEY_BITS-1:0] keys
);

  logic [1:0] lx_dir, ly_dir, rx_dir, ry_dir;

  // Bit 0 of each pair is the low direction, bit 1 the high direction.
  function automatic logic [1:0] axis_dir(input logic [AXIS_BITS-1:0] v);
    logic [1:0] d;
    d = 2'b00;
    if (v < AXIS_LOW) begin
      d = 2'b01;
    end else if (v > AXIS_HIGH) begin
      d = 2'b10;
    end
    return d;
  endfunction

  always_comb begin
    lx_dir = axis_dir(item.left_x);
    ly_dir = axis_dir(item.left_y);
    rx_dir = axis_dir(item.right_x);
    ry_dir = axis_dir(item.right_y);
    keys   = {ry_dir, rx_dir, ly_dir, lx_dir, item.buttons};
  end

endmodule

[rtl/bta_turbo.sv]
// Per-key repeat timers: due-time registers and the parallel due compare.
// Depends on bta_pkg.
module bta_turbo
  import bta_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  cfg_t                 cfg,
  input  logic [KEY_BITS-1:0]  keys,
  input  logic [KEY_BITS-1:0]  previous_keys,
  input  logic [TIME_BITS-1:0] now,
  output logic [KEY_BITS-1:0]  repeat_mask
);

  localparam int NUM_TIMERS = (NUM_KEYS < KEY_BITS) ? NUM_KEYS : KEY_BITS;

  logic [TIME_BITS:0]   start_sum, interval_sum;
  logic [TIME_BITS-1:0] start_due, interval_due;

  // Both sums are shared by all keys; the carry out means saturation.
  always_comb begin
    start_sum    = {1'b0, now} + (TIME_BITS + 1)'(cfg.start_delay);
    interval_sum = {1'b0, now} + (TIME_BITS + 1)'(cfg.repeat_interval);
    start_due    = start_sum[TIME_BITS] ? TIME_MAX : start_sum[TIME_BITS-1:0];
    interval_due = interval_sum[TIME_BITS] ? TIME_MAX : interval_sum[TIME_BITS-1:0];
  end

  generate
    if (NUM_TIMERS < KEY_BITS) begin : g_pad
      assign repeat_mask[KEY_BITS-1:NUM_TIMERS] = '0;
    end

    for (genvar k = 0; k < NUM_TIMERS; k++) begin : g_key
      logic [TIME_BITS-1:0] due;
      logic [TIME_BITS-1:0] due_next;
      logic                 fire;

      always_comb begin
        fire     = 1'b0;
        due_next = due;
        if (cfg.turbo_mask[k]) begin
          if (keys[k] && !previous_keys[k]) begin
            due_next = start_due;
          end else if (keys[k] && previous_keys[k] && (now >= due)) begin
            fire     = 1'b1;
            due_next = interval_due;
          end else if (!keys[k] && previous_keys[k]) begin
            due_next = '0;
          end
        end
      end

      assign repeat_mask[k] = fire;

      always_ff @(posedge clk) begin
        if (rst) begin
          due <= '0;
        end else if (update) begin
          due <= due_next;
        end
      end
    end
  endgenerate

endmodule

[rtl/button_turbo_autorepeat_top.sv]
// Top level of the button turbo auto-repeat block: handshakes, config
// registers, previous key word and result register. Depends on bta_pkg,
// bta_key_map and bta_turbo.
//
// Usage: each input item is one controller poll (buttons, four stick axes,
// current time). Each accepted item yields exactly one result item with the
// key word, pressed and released masks and a changed flag.
// Both channels use valid/stall; an item moves at an edge with valid high
// and stall low. The input register feeds one pass of logic (key mapping,
// 32 parallel due-time compares, two shared saturating adds) that writes
// the result register and the key state at the same edge.
// The item passes through the input register and then the result register.
// Throughput: one item per cycle unless stalled; the previous key word and
// due times update at the edge the item enters the result register, so the
// next item, already in the input register, sees them in the following cycle.
// When the receiver stalls, the result holds and one more item waits in the
// input register; only then is in_stall raised.
// Reset (synchronous, active high) clears both channels, the previous key
// word and all due times, and loads the config registers with their
// defaults (turbo mask 0, start delay 500000, repeat interval 100000).
// Config writes take effect at the edge cfg_we is seen; write only while idle.
module button_turbo_autorepeat_top
  import bta_pkg::*;
#(
  parameter int NUM_KEYS = NUM_KEYS_DEF
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  in_item_t                  in_data,
  output logic                      out_valid,
  input  logic                      out_stall,
  output out_item_t                 out_data,
  input  logic                      cfg_we,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  cfg_t                cfg;
  logic                s1_valid;
  in_item_t            s1_item;
  logic [KEY_BITS-1:0] previous_keys;
  logic [KEY_BITS-1:0] keys;
  logic [KEY_BITS-1:0] repeat_mask;
  logic [KEY_BITS-1:0] eff_prev;
  out_item_t           result;
  logic                advance;
  logic                accept_in;

  assign advance   = s1_valid && (!out_valid || !out_stall);
  assign in_stall  = s1_valid && out_valid && out_stall;
  assign accept_in = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.turbo_mask      <= '0;
      cfg.start_delay     <= START_DELAY_RST;
      cfg.repeat_interval <= REPEAT_INTERVAL_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_TURBO_MASK:      cfg.turbo_mask      <= cfg_data;
        CFG_START_DELAY:     cfg.start_delay     <= cfg_data;
        CFG_REPEAT_INTERVAL: cfg.repeat_interval <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept_in) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_in) begin
      s1_item <= in_data;
    end
  end

  bta_key_map u_key_map (
    .item (s1_item),
    .keys (keys)
  );

  bta_turbo #(
    .NUM_KEYS (NUM_KEYS)
  ) u_turbo (
    .clk           (clk),
    .rst           (rst),
    .update        (advance),
    .cfg           (cfg),
    .keys          (keys),
    .previous_keys (previous_keys),
    .now           (s1_item.now),
    .repeat_mask   (repeat_mask)
  );

  // A key that repeats this poll is treated as not held before.
  always_comb begin
    eff_prev        = previous_keys & ~repeat_mask;
    result.keys     = keys;
    result.pressed  = keys & ~eff_prev;
    result.released = eff_prev & ~keys;
    result.changed  = (keys != eff_prev);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_keys <= '0;
    end else if (advance) begin
      previous_keys <= keys;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_data <= result;
    end
  end

endmodule

[tb/button_turbo_autorepeat_top_tb.sv]
// Self-checking testbench for button_turbo_autorepeat_top: directed polls, then random
// held-key sequences under several idle mixes and one long output hold.
// Depends on bta_pkg and the block's RTL only.
module button_turbo_autorepeat_top_tb;
  import bta_pkg::*;

  // Index 3 has no register behind it; writes to it must change nothing.
  localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
  localparam int PHASE_POLLS = 320;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      in_valid  = 1'b0;
  in_item_t                  in_data   = '0;
  logic                      out_stall = 1'b0;
  logic                      cfg_we    = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = CFG_TURBO_MASK;
  logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;
  logic                      in_stall;
  logic                      out_valid;
  out_item_t                 out_data;

  button_turbo_autorepeat_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // Shadow copy of the registers and key state.
  logic [KEY_BITS-1:0]      shadow_mask     = '0;
  logic [CFG_DATA_BITS-1:0] shadow_start    = START_DELAY_RST;
  logic [CFG_DATA_BITS-1:0] shadow_interval = REPEAT_INTERVAL_RST;
  logic [KEY_BITS-1:0]      last_keys       = '0;
  logic [TIME_BITS-1:0]     due_time [KEY_BITS];

  out_item_t            expected_results [$];
  out_item_t            want;
  logic [KEY_BITS-1:0]  held_keys = '0;
  logic [TIME_BITS-1:0] poll_time = '0;
  int error_count     = 0;
  int polls_accepted  = 0;
  int results_checked = 0;
  int send_idle_pct   = 0;
  int stall_pct       = 0;
  int hold_left       = 0;

  initial begin
    for (int k = 0; k < KEY_BITS; k++) due_time[k] = '0;
  end

  function automatic logic [TIME_BITS-1:0] sat_sum(logic [TIME_BITS-1:0] a,
                                                   logic [CFG_DATA_BITS-1:0] b);
    logic [TIME_BITS:0] s;
    s = {1'b0, a} + {{(TIME_BITS+1-CFG_DATA_BITS){1'b0}}, b};
    return s[TIME_BITS] ? TIME_MAX : s[TIME_BITS-1:0];
  endfunction

  // Returns {high, low} direction bits of one stick axis.
  function automatic logic [1:0] stick_dir(logic [AXIS_BITS-1:0] v);
    if (v < AXIS_LOW) return 2'b01;
    if (v > AXIS_HIGH) return 2'b10;
    return 2'b00;
  endfunction

  function automatic out_item_t poll_result(in_item_t it);
    logic [KEY_BITS-1:0] keys;
    logic [KEY_BITS-1:0] eff;
    out_item_t r;
    keys = {stick_dir(it.right_y), stick_dir(it.right_x),
            stick_dir(it.left_y), stick_dir(it.left_x), it.buttons};
    eff = last_keys;
    for (int k = 0; k < KEY_BITS; k++) begin
      if (shadow_mask[k]) begin
        if (keys[k]) begin
          if (!last_keys[k]) begin
            due_time[k] = sat_sum(it.now, shadow_start);
          end else if (it.now >= due_time[k]) begin
            // A repeat looks like a fresh press, so the key leaves the old word.
            eff[k] = 1'b0;
            due_time[k] = sat_sum(it.now, shadow_interval);
          end
        end else if (last_keys[k]) begin
          due_time[k] = '0;
        end
      end
    end
    r.keys     = keys;
    r.pressed  = keys & ~eff;
    r.released = eff & ~keys;
    r.changed  = (keys != eff);
    last_keys  = keys;
    return r;
  endfunction

  function automatic in_item_t raw_poll(logic [BUTTON_BITS-1:0] b, logic [AXIS_BITS-1:0] lx,
                                        logic [AXIS_BITS-1:0] ly, logic [AXIS_BITS-1:0] rx,
                                        logic [AXIS_BITS-1:0] ry, logic [TIME_BITS-1:0] t);
    in_item_t it;
    it.buttons = b;
    it.left_x  = lx;
    it.left_y  = ly;
    it.right_x = rx;
    it.right_y = ry;
    it.now     = t;
    return it;
  endfunction

  function automatic logic [AXIS_BITS-1:0] axis_value(logic lo, logic hi);
    if (lo) return AXIS_BITS'($urandom_range(0, 63));
    if (hi) return AXIS_BITS'($urandom_range(193, 255));
    return AXIS_BITS'($urandom_range(64, 192));
  endfunction

  function automatic in_item_t poll_of(logic [KEY_BITS-1:0] keys, logic [TIME_BITS-1:0] t);
    return raw_poll(keys[23:0], axis_value(keys[24], keys[25]), axis_value(keys[26], keys[27]),
                    axis_value(keys[28], keys[29]), axis_value(keys[30], keys[31]), t);
  endfunction

  // Input side: predict every item at the edge that accepts it.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) begin
      expected_results.push_back(poll_result(in_data));
      polls_accepted++;
    end
  end

  task automatic compare_field(string name, logic [KEY_BITS-1:0] exp_v,
                               logic [KEY_BITS-1:0] got_v);
    if (exp_v !== got_v) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, got_v);
      error_count++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: result with nothing expected, expected none, actual %h",
                 $time, out_data);
        error_count++;
      end else begin
        want = expected_results.pop_front();
        compare_field("keys", want.keys, out_data.keys);
        compare_field("pressed", want.pressed, out_data.pressed);
        compare_field("released", want.released, out_data.released);
        compare_field("changed", KEY_BITS'(want.changed), KEY_BITS'(out_data.changed));
        results_checked++;
      end
    end
  end

  // Receiver: random stalls, or a long counted hold when one is requested.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left = hold_left - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  task automatic send_poll(in_item_t it);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic settle_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      CFG_TURBO_MASK:      shadow_mask = val;
      CFG_START_DELAY:     shadow_start = val;
      CFG_REPEAT_INTERVAL: shadow_interval = val;
      default: ;
    endcase
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic test_reset_defaults();
    // Turbo mask is zero after reset, so a long hold never repeats.
    send_poll(poll_of(32'h0000_0008, 48'd0));
    send_poll(poll_of(32'h0000_0008, 48'd600000));
    send_poll(poll_of(32'h0000_0000, 48'd700000));
  endtask

  task automatic test_stick_extremes();
    send_poll(raw_poll(24'hFFFFFF, 8'd0, 8'd255, 8'd63, 8'd193, 48'd10));
    send_poll(raw_poll(24'h000000, 8'd64, 8'd192, 8'd128, 8'd128, 48'd11));
    send_poll(raw_poll(24'hFFFFFF, 8'd255, 8'd0, 8'd193, 8'd63, 48'd12));
    send_poll(raw_poll(24'h5A5A5A, 8'd62, 8'd194, 8'd65, 8'd191, 48'd13));
    send_poll(raw_poll(24'h000000, 8'd128, 8'd128, 8'd128, 8'd128, 48'd14));
  endtask

  task automatic test_turbo_repeat();
    settle_idle();
    write_reg(CFG_TURBO_MASK, 32'hFFFF_FFFF);
    write_reg(CFG_START_DELAY, 32'd3);
    write_reg(CFG_REPEAT_INTERVAL, 32'd2);
    send_poll(poll_of(32'h8100_0001, 48'd100));
    send_poll(poll_of(32'h8100_0001, 48'd102));
    send_poll(poll_of(32'h8100_0001, 48'd103));
    send_poll(poll_of(32'h8100_0001, 48'd104));
    send_poll(poll_of(32'h8100_0001, 48'd105));
  endtask

  task automatic test_time_saturation();
    settle_idle();
    write_reg(CFG_START_DELAY, 32'hFFFF_FFFF);
    write_reg(CFG_REPEAT_INTERVAL, 32'hFFFF_FFFF);
    send_poll(poll_of(32'h0000_0000, TIME_MAX - 48'd10));
    send_poll(poll_of(32'h0000_0001, TIME_MAX - 48'd5));
    send_poll(poll_of(32'h0000_0001, TIME_MAX - 48'd1));
    // The saturated due time is reached only at the top, then fires every poll.
    send_poll(poll_of(32'h0000_0001, TIME_MAX));
    send_poll(poll_of(32'h0000_0001, TIME_MAX));
  endtask

  task automatic test_mask_toggle();
    settle_idle();
    write_reg(CFG_TURBO_MASK, 32'h0000_0000);
    send_poll(poll_of(32'h0000_0003, 48'd10));
    settle_idle();
    write_reg(CFG_UNUSED, $urandom);
    // Key 1 was never held while its mask bit was set, so its due time is still zero and fires at once.
    write_reg(CFG_TURBO_MASK, 32'h0000_0003);
    send_poll(poll_of(32'h0000_0003, 48'd11));
    send_poll(poll_of(32'h0000_0003, 48'd12));
  endtask

  task automatic test_time_backwards();
    settle_idle();
    write_reg(CFG_START_DELAY, 32'd0);
    write_reg(CFG_REPEAT_INTERVAL, 32'd0);
    send_poll(poll_of(32'h0000_0004, 48'd1000));
    send_poll(poll_of(32'h0000_0004, 48'd999));
    send_poll(poll_of(32'h0000_0004, 48'd1000));
    send_poll(poll_of(32'h0000_0004, 48'd500));
  endtask

  task automatic run_random_polls(int count);
    in_item_t it;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(99) < 15) begin
        it = raw_poll(BUTTON_BITS'($urandom), AXIS_BITS'($urandom), AXIS_BITS'($urandom),
                      AXIS_BITS'($urandom), AXIS_BITS'($urandom),
                      TIME_BITS'({$urandom, $urandom}));
        if ($urandom_range(9) == 0) it.now = TIME_MAX - TIME_BITS'($urandom_range(20));
        if ($urandom_range(1) == 1) poll_time = it.now;
      end else begin
        // Each key flips with a probability of one in sixteen, so holds span many polls.
        held_keys ^= $urandom & $urandom & $urandom & $urandom;
        if ($urandom_range(49) == 0) poll_time -= TIME_BITS'($urandom_range(1, 8));
        else poll_time += TIME_BITS'($urandom_range(0, 3));
        it = poll_of(held_keys, poll_time);
      end
      send_poll(it);
    end
  endtask

  task automatic test_random_phase(int idle_pct, int stall_in_pct, logic [KEY_BITS-1:0] mask);
    settle_idle();
    write_reg(CFG_TURBO_MASK, mask);
    write_reg(CFG_START_DELAY, CFG_DATA_BITS'($urandom_range(0, 12)));
    write_reg(CFG_REPEAT_INTERVAL, CFG_DATA_BITS'($urandom_range(0, 6)));
    send_idle_pct = idle_pct;
    stall_pct     = stall_in_pct;
    run_random_polls(PHASE_POLLS);
  endtask

  task automatic test_backpressure();
    settle_idle();
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 200;
    run_random_polls(40);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_stick_extremes();
    test_turbo_repeat();
    test_time_saturation();
    test_mask_toggle();
    test_time_backwards();
    test_random_phase(0, 0, 32'hFFFF_FFFF);
    test_random_phase(65, 0, $urandom);
    test_random_phase(0, 65, $urandom | 32'hFF00_0000);
    test_random_phase(29, 29, $urandom);
    test_backpressure();
    settle_idle();
    $display("Checked %0d results from %0d polls: directed corner cases, four idle mixes",
             results_checked, polls_accepted);
    $display("and a long output hold that backed up the input.");
    if (error_count == 0) begin
      $display("[button_turbo_autorepeat_top] OK");
    end else begin
      $display("[button_turbo_autorepeat_top] ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("Timed out with %0d results still expected.", expected_results.size());
    $display("[button_turbo_autorepeat_top] ERROR");
    $finish;
  end

endmodule

[sim.f]
rtl/bta_pkg.sv
rtl/bta_key_map.sv
rtl/bta_turbo.sv
rtl/button_turbo_autorepeat_top.sv
tb/button_turbo_autorepeat_top_tb.sv
